// ===== src/pcd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pcd_pkg
// Shared widths, the reset constant and the command bundle that the controller
// sends to the datapath of the per-identifier cooldown table.
// ----------------------------------------------------------------------------
package pcd_pkg;

    localparam int ID_W   = 32;
    localparam int TIME_W = 64;

    // Reset value of the cooldown register: one second in nanoseconds.
    localparam logic [TIME_W-1:0] COOLDOWN_RESET = 64'd1000000000;

    typedef struct packed {
        logic load;      // capture the incoming item and restart the scan
        logic scan;      // read the next entry and evaluate the previous one
        logic commit;    // update the table and form the answer
        logic out_load;  // move the answer into the output register
    } pcd_cmd_t;

endpackage : pcd_pkg
`default_nettype wire

// ===== src/pcd_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pcd_datapath
// Entry memories, valid bits, scan counter, hit detection, least recently
// used victim tracking and the answer registers.
// ----------------------------------------------------------------------------
module pcd_datapath
    import pcd_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire pcd_cmd_t          cmd,
    input  wire logic              cfg_we,
    input  wire logic [TIME_W-1:0] cfg_data,
    input  wire logic [ID_W-1:0]   ident,
    input  wire logic [TIME_W-1:0] now_ns,
    output logic                   scan_done,
    output logic                   due
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(TABLE_DEPTH);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);

    logic [ID_W-1:0]        ident_mem [TABLE_DEPTH];
    logic [TIME_W-1:0]      time_mem  [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] slot_valid_reg;

    logic [TIME_W-1:0] cooldown_reg;
    logic [ID_W-1:0]   ident_reg;
    logic [TIME_W-1:0] now_reg;

    logic [CNT_W-1:0]  rd_cnt_reg;
    logic              pend_reg;
    logic [IDX_W-1:0]  pend_idx_reg;
    logic [ID_W-1:0]   rd_ident_reg;
    logic [TIME_W-1:0] rd_time_reg;
    logic              rd_bit_reg;

    logic              hit_reg;
    logic [IDX_W-1:0]  hit_idx_reg;
    logic              cool_reg;
    logic              ev_last_reg;
    logic              have_free_reg;
    logic [IDX_W-1:0]  victim_idx_reg;
    logic [TIME_W-1:0] victim_time_reg;
    logic              due_res_reg;
    logic              due_reg;

    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              ev_en;
    logic              match;
    logic [TIME_W-1:0] elapsed;
    logic              cooling;

    assign rd_en   = cmd.scan && (rd_cnt_reg < CNT_END);
    assign rd_addr = rd_cnt_reg[IDX_W-1:0];
    assign ev_en   = cmd.scan && pend_reg && !hit_reg && !ev_last_reg;
    assign match   = rd_bit_reg && (rd_ident_reg == ident_reg);
    assign elapsed = now_reg - rd_time_reg;
    assign cooling = elapsed < cooldown_reg;

    assign scan_done = hit_reg || ev_last_reg;
    assign due       = due_reg;

    // Entry memories and the registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.commit) begin
            if (hit_reg) begin
                if (!cool_reg) begin
                    time_mem[hit_idx_reg] <= now_reg;
                end
            end else begin
                ident_mem[victim_idx_reg] <= ident_reg;
                time_mem[victim_idx_reg]  <= now_reg;
            end
        end
        if (rd_en) begin
            rd_ident_reg <= ident_mem[rd_addr];
            rd_time_reg  <= time_mem[rd_addr];
            rd_bit_reg   <= slot_valid_reg[rd_addr];
            pend_idx_reg <= rd_addr;
        end
    end

    // Item capture, victim tracking and answer payload.
    always_ff @(posedge clk)
    begin
        if (cmd.load) begin
            ident_reg <= ident;
            now_reg   <= now_ns;
        end
        if (ev_en && !match && !have_free_reg) begin
            // Slot 0 seeds the victim; a later slot replaces it when free or strictly older.
            if (pend_idx_reg == '0) begin
                victim_idx_reg  <= '0;
                victim_time_reg <= rd_time_reg;
            end else if (!rd_bit_reg) begin
                victim_idx_reg  <= pend_idx_reg;
            end else if (rd_time_reg < victim_time_reg) begin
                victim_idx_reg  <= pend_idx_reg;
                victim_time_reg <= rd_time_reg;
            end
        end
        if (ev_en && match) begin
            hit_idx_reg <= pend_idx_reg;
            cool_reg    <= cooling;
        end
        if (cmd.commit) begin
            due_res_reg <= !(hit_reg && cool_reg);
        end
        if (cmd.out_load) begin
            due_reg <= due_res_reg;
        end
    end

    // Control state of the scan, valid bits and the cooldown register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            slot_valid_reg <= '0;
            cooldown_reg   <= COOLDOWN_RESET;
            rd_cnt_reg     <= '0;
            pend_reg       <= 1'b0;
            hit_reg        <= 1'b0;
            ev_last_reg    <= 1'b0;
            have_free_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                cooldown_reg <= cfg_data;
            end
            if (cmd.load) begin
                rd_cnt_reg    <= '0;
                pend_reg      <= 1'b0;
                hit_reg       <= 1'b0;
                ev_last_reg   <= 1'b0;
                have_free_reg <= 1'b0;
            end else if (cmd.scan) begin
                pend_reg <= rd_en;
                if (rd_en) begin
                    rd_cnt_reg <= rd_cnt_reg + 1'b1;
                end
                if (ev_en) begin
                    ev_last_reg <= (pend_idx_reg == IDX_LAST);
                    if (match) begin
                        hit_reg <= 1'b1;
                    end else if (!have_free_reg && !rd_bit_reg) begin
                        have_free_reg <= 1'b1;
                    end
                end
            end
            if (cmd.commit && !hit_reg) begin
                slot_valid_reg[victim_idx_reg] <= 1'b1;
            end
        end
    end

endmodule : pcd_datapath
`default_nettype wire

// ===== src/pcd_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pcd_ctrl
// Sequencer for one lookup: capture, table scan, update, answer hand-off.
// Owns the output valid flag.
// ----------------------------------------------------------------------------
module pcd_ctrl
    import pcd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    input  wire logic scan_done,
    output pcd_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT,
        ST_DELIVER
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd          = '0;
        cmd.load     = (state_reg == ST_IDLE) && in_valid;
        cmd.scan     = (state_reg == ST_SCAN);
        cmd.commit   = (state_reg == ST_COMMIT);
        cmd.out_load = (state_reg == ST_DELIVER) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_valid) begin
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (scan_done) begin
                        state_reg <= ST_COMMIT;
                    end
                end
                ST_COMMIT: begin
                    state_reg <= ST_DELIVER;
                end
                ST_DELIVER: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule : pcd_ctrl
`default_nettype wire

// ===== src/per_id_cooldown_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// per_id_cooldown_table
// Per-identifier cooldown filter with a table of TABLE_DEPTH entries and
// least recently used replacement when the table is full.
// ----------------------------------------------------------------------------
//  Channel | Handshake            | Payload
//  --------+----------------------+----------------------------
//  cfg     | cfg_valid/cfg_ready  | cooldown_ns[63:0]
//  in      | in_valid/in_ready    | ident[31:0], now_ns[63:0]
//  out     | out_valid/out_ready  | due
//
// An item passes from accept to the next accept through a capture step, a
// scan over the single read port of the entry memories (shorter when the
// identifier is found early), an update step and a hand-off step into the
// output register.
// Reset clears all valid bits and loads a cooldown of one second.
// A stalled output holds the block in hand-off; cfg_ready is always high.
// ----------------------------------------------------------------------------
module per_id_cooldown_table
    import pcd_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [TIME_W-1:0] cooldown_ns,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [ID_W-1:0]   ident,
    input  wire logic [TIME_W-1:0] now_ns,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   due
);

    pcd_cmd_t cmd;
    logic     scan_done;

    assign cfg_ready = 1'b1;

    pcd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .scan_done (scan_done),
        .cmd       (cmd)
    );

    pcd_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_data  (cooldown_ns),
        .ident     (ident),
        .now_ns    (now_ns),
        .scan_done (scan_done),
        .due       (due)
    );

    // Only one item is in flight: the block is busy right after an accept.
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready
    ) else $error("input accepted while an item is still in flight");

    // The table is updated exactly once per item, always right after the scan.
    a_commit_after_scan: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.commit |-> ($past(cmd.scan) && $past(scan_done))
    ) else $error("table update without a finished scan");

    // A new answer never overwrites one that has not been taken.
    a_no_overwrite: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid || out_ready)
    ) else $error("answer loaded over a pending item");

endmodule : per_id_cooldown_table
`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the per-identifier cooldown table. A scoreboard
// keeps its own copy of the table and the cooldown register. It predicts the
// due answer of every accepted request and checks answers in order. Directed
// requests cover the field extremes, wrapping time, zero and maximum
// cooldown, and eviction from a full table with ties. Three random phases
// with different cooldowns and handshake idling follow. In each phase a small
// pool of identifiers receives advancing timestamps, with some noise mixed in.
// ----------------------------------------------------------------------------
module tb_top;
    import pcd_pkg::*;

    localparam int TB_DEPTH   = 16;
    localparam int POOL_SIZE  = 20;
    localparam int PHASE_ITEMS = 430;
    localparam int STALL_LIMIT = 2000;

    class cooldown_scoreboard;
        bit              entry_used  [TB_DEPTH];
        bit [ID_W-1:0]   entry_ident [TB_DEPTH];
        bit [TIME_W-1:0] entry_stamp [TB_DEPTH];
        bit [TIME_W-1:0] cooldown;
        bit              due_expected [$];
        int errors;
        int n_requests;
        int n_results;
        int n_due;
        int n_held;
        int n_evicted;
        int n_settings;

        function void clear_table();
            foreach (entry_used[k])
                entry_used[k] = 1'b0;
            cooldown = COOLDOWN_RESET;
        endfunction

        function void set_cooldown(bit [TIME_W-1:0] value);
            cooldown = value;
            n_settings++;
        endfunction

        function int pending();
            return due_expected.size();
        endfunction

        // Walks the table like the block does: a hit ends the walk, and until
        // a free entry turns up the oldest stamp is tracked as the victim.
        function bit predict_due(bit [ID_W-1:0] id, bit [TIME_W-1:0] now);
            int              victim;
            bit              have_free;
            bit [TIME_W-1:0] elapsed;
            victim    = 0;
            have_free = 1'b0;
            for (int k = 0; k < TB_DEPTH; k++)
            begin
                if (entry_used[k] && entry_ident[k] == id)
                begin
                    elapsed = now - entry_stamp[k];
                    if (elapsed < cooldown)
                        return 1'b0;
                    entry_stamp[k] = now;
                    return 1'b1;
                end
                if (!have_free)
                begin
                    if (!entry_used[k])
                    begin
                        victim    = k;
                        have_free = 1'b1;
                    end
                    else if (entry_stamp[k] < entry_stamp[victim])
                    begin
                        victim = k;
                    end
                end
            end
            if (!have_free)
                n_evicted++;
            entry_used[victim]  = 1'b1;
            entry_ident[victim] = id;
            entry_stamp[victim] = now;
            return 1'b1;
        endfunction

        function void note_request(bit [ID_W-1:0] id, bit [TIME_W-1:0] now);
            bit answer;
            answer = predict_due(id, now);
            n_requests++;
            if (answer)
                n_due++;
            else
                n_held++;
            due_expected.push_back(answer);
        endfunction

        function void check_answer(logic got);
            bit want;
            n_results++;
            if (due_expected.size() == 0)
            begin
                $display("%0t: due = %0b arrived with no request outstanding", $time, got);
                errors++;
                return;
            end
            want = due_expected.pop_front();
            if (got !== want)
            begin
                $display("%0t: due mismatch, expected %0b, actual %0b", $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n       = 1'b0;
    logic              cfg_valid   = 1'b0;
    logic              cfg_ready;
    logic [TIME_W-1:0] cooldown_ns = '0;
    logic              in_valid    = 1'b0;
    logic              in_ready;
    logic [ID_W-1:0]   ident       = '0;
    logic [TIME_W-1:0] now_ns      = '0;
    logic              out_valid;
    logic              out_ready   = 1'b0;
    logic              due;

    cooldown_scoreboard sb;
    int                 send_idle_pct = 29;
    int                 recv_idle_pct = 55;
    int                 idle_cycles   = 0;
    logic [ID_W-1:0]    id_pool [POOL_SIZE];

    per_id_cooldown_table #(
        .TABLE_DEPTH(TB_DEPTH)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cooldown_ns(cooldown_ns),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .ident      (ident),
        .now_ns     (now_ns),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .due        (due)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_answer(due);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_request(input logic [ID_W-1:0] id, input logic [TIME_W-1:0] stamp);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        ident    <= id;
        now_ns   <= stamp;
        do @(posedge clk); while (!in_ready);
        sb.note_request(id, stamp);
    endtask

    task automatic wait_for_answers();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    // Waits for every outstanding answer, then idles before the next cooldown write.
    task automatic quiesce();
        wait_for_answers();
        repeat (TB_DEPTH + 5) @(posedge clk);
    endtask

    task automatic write_cooldown(input logic [TIME_W-1:0] value);
        cfg_valid   <= 1'b1;
        cooldown_ns <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_cooldown(value);
    endtask

    // Most requests come from the pool with a rising time base, so entries are
    // revisited both inside and outside the cooldown. Some step back in time
    // and a few are fully random.
    task automatic run_random(input int count, input logic [TIME_W-1:0] start);
        logic [TIME_W-1:0] base;
        logic [TIME_W-1:0] span;
        logic [TIME_W-1:0] stamp;
        logic [ID_W-1:0]   id;
        int                pick;
        base = start;
        span = sb.cooldown / 6 + 1;
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, 99);
            id   = id_pool[$urandom_range(0, POOL_SIZE - 1)];
            if (pick < 8)
            begin
                id    = $urandom;
                stamp = {$urandom, $urandom};
            end
            else if (pick < 14)
            begin
                stamp = base - ({$urandom, $urandom} % span);
            end
            else
            begin
                // Holding the base now and then gives equal stamps and thus ties.
                if (pick >= 24)
                    base = base + ({$urandom, $urandom} % span);
                stamp = base;
            end
            send_request(id, stamp);
            if ($urandom_range(0, 199) == 0)
                wait_for_answers();
        end
    endtask

    initial
    begin
        sb = new();
        sb.clear_table();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(32'h0000_0000, 64'd0);
        send_request(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(32'h0000_0000, 64'd999_999_999);
        send_request(32'h0000_0000, 64'd1_000_000_000);
        // The difference wraps past zero, so this one is still cooling down.
        send_request(32'hFFFF_FFFF, 64'd5);
        send_request(32'h0000_0000, 64'd10);
        for (int k = 1; k <= 14; k++)
            send_request(k, 64'd100);
        // Table is full: the oldest entry goes first, then the lowest of a tie.
        send_request(32'h5555_5555, 64'd200);
        send_request(32'hAAAA_AAAA, 64'd200);
        send_request(32'h0000_0001, 64'd201);
        send_request(32'h0000_0000, 64'd300);
        wait_for_answers();

        quiesce();
        write_cooldown('0);
        send_request(32'd4, 64'd100);
        quiesce();
        write_cooldown('1);
        send_request(32'd5, 64'd50);

        foreach (id_pool[k])
            id_pool[k] = $urandom;

        quiesce();
        write_cooldown(64'd1000);
        run_random(PHASE_ITEMS, 64'd5000);

        quiesce();
        write_cooldown(64'd1 + $urandom_range(0, 24'hFF_FFFF));
        send_idle_pct = 55;
        recv_idle_pct = 29;
        run_random(PHASE_ITEMS, {$urandom, $urandom} >> 8);

        quiesce();
        write_cooldown(COOLDOWN_RESET);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // Starting just below the wrap point lets stamps roll over to zero.
        run_random(PHASE_ITEMS, 64'hFFFF_FFFF_0000_0000);

        wait_for_answers();
        repeat (TB_DEPTH + 8) @(posedge clk);
        if (sb.pending() != 0)
        begin
            $display("%0t: %0d answers never arrived", $time, sb.pending());
            sb.errors++;
        end

        $display("Covered %0d requests (%0d due, %0d held back, %0d evictions) under %0d cooldowns.",
                 sb.n_requests, sb.n_due, sb.n_held, sb.n_evicted, sb.n_settings);
        $display("Checked %0d answers with %0d mismatches.", sb.n_results, sb.errors);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== per_id_cooldown_table.f =====
src/pcd_pkg.sv
src/pcd_datapath.sv
src/pcd_ctrl.sv
src/per_id_cooldown_table.sv
test/tb_top.sv
